### rtl/scc_pkg.sv
// Shared types and constants for the sliding complex correlator with peak detection.
// Used by scc_mac, scc_power and the top module; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

   // Fixed field widths
   localparam int PLEN_BITS      = 8;
   localparam int TAP_INDEX_BITS = 7;
   localparam int CORR_BITS      = 32;
   localparam int POWER_BITS     = 62;

   localparam logic [PLEN_BITS-1:0] PLEN_RESET = 8'd64;

   // Input command codes
   localparam logic CMD_LOAD_TAP = 1'b0;
   localparam logic CMD_PUSH     = 1'b1;

   // Result kinds
   localparam logic KIND_CORR = 1'b0;
   localparam logic KIND_PEAK = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_SQUARE,
      ST_COMBINE,
      ST_POWER,
      ST_EMIT_CORR,
      ST_EMIT_PEAK
   } scc_state_type;

   // Multiply-accumulate control
   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctrl_type;

   // Power unit stage enables
   typedef struct packed {
      logic sq_en;
      logic comb_en;
      logic pow_en;
   } pwr_ctrl_type;

endpackage

`default_nettype wire

### rtl/scc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies; used for the tap store and the sample window.
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/scc_mac.sv
// Complex multiply-accumulate over taps and window samples read from RAM.
// Depends on scc_pkg (mac_ctrl_type).
`timescale 1ns / 1ps
`default_nettype none

module scc_mac #(
   parameter int SAMPLE_BITS = 12,
   parameter int ACC_W       = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scc_pkg::mac_ctrl_type     ctrl,
   input  logic [2*SAMPLE_BITS-1:0]  tap_word,
   input  logic [2*SAMPLE_BITS-1:0]  win_word,
   output logic signed [ACC_W-1:0]   acc_re,
   output logic signed [ACC_W-1:0]   acc_im,
   output logic                      busy
);

   localparam int PW = 2 * SAMPLE_BITS;

   logic signed [SAMPLE_BITS-1:0] dr, di, tr, ti;
   logic signed [PW-1:0]          p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                          rd_v_ff, mul_v_ff;
   logic signed [ACC_W-1:0]       acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_W-1:0]       term_re, term_im;

   // unpack {re, im}
   assign dr = win_word[PW-1:SAMPLE_BITS];
   assign di = win_word[SAMPLE_BITS-1:0];
   assign tr = tap_word[PW-1:SAMPLE_BITS];
   assign ti = tap_word[SAMPLE_BITS-1:0];

   // pipeline valids: read data, then products
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= ctrl.issue;
         mul_v_ff <= rd_v_ff;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         p_rr_ff <= dr * tr;
         p_ii_ff <= di * ti;
         p_ri_ff <= dr * ti;
         p_ir_ff <= di * tr;
      end
   end

   // accumulate stage
   always_comb begin
      term_re   = {{(ACC_W-PW){p_rr_ff[PW-1]}}, p_rr_ff}
                - {{(ACC_W-PW){p_ii_ff[PW-1]}}, p_ii_ff};
      term_im   = {{(ACC_W-PW){p_ri_ff[PW-1]}}, p_ri_ff}
                + {{(ACC_W-PW){p_ir_ff[PW-1]}}, p_ir_ff};
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctrl.clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (mul_v_ff) begin
         acc_re_in = acc_re_ff + term_re;
         acc_im_in = acc_im_ff + term_im;
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
   assign busy   = rd_v_ff | mul_v_ff;

endmodule

`default_nettype wire

### rtl/scc_power.sv
// Squared magnitude of the complex sum, built from split partial products.
// Depends on scc_pkg (pwr_ctrl_type, POWER_BITS).
`timescale 1ns / 1ps
`default_nettype none

module scc_power #(
   parameter int ACC_W = 32
) (
   input  logic                             clock,
   input  scc_pkg::pwr_ctrl_type            ctrl,
   input  logic signed [ACC_W-1:0]          acc_re,
   input  logic signed [ACC_W-1:0]          acc_im,
   output logic [scc_pkg::POWER_BITS-1:0]   power
);

   // magnitude split into low H bits and high HW bits
   localparam int H  = (ACC_W + 1) / 2;
   localparam int HW = ACC_W - H;

   logic [ACC_W-1:0]     acc_re_u, acc_im_u, mag_re, mag_im;
   logic [2*H-1:0]       ll_re_ff, ll_im_ff;
   logic [HW+H-1:0]      hl_re_ff, hl_im_ff;
   logic [2*HW-1:0]      hh_re_ff, hh_im_ff;
   logic [63:0]          sq_re_ff, sq_im_ff, sq_sum;
   logic [scc_pkg::POWER_BITS-1:0] power_ff;

   // absolute values
   always_comb begin
      acc_re_u = acc_re;
      acc_im_u = acc_im;
      mag_re   = acc_re_u[ACC_W-1] ? (~acc_re_u + 1'b1) : acc_re_u;
      mag_im   = acc_im_u[ACC_W-1] ? (~acc_im_u + 1'b1) : acc_im_u;
   end

   // partial products
   always_ff @(posedge clock) begin
      if (ctrl.sq_en) begin
         ll_re_ff <= mag_re[H-1:0] * mag_re[H-1:0];
         hl_re_ff <= mag_re[ACC_W-1:H] * mag_re[H-1:0];
         hh_re_ff <= mag_re[ACC_W-1:H] * mag_re[ACC_W-1:H];
         ll_im_ff <= mag_im[H-1:0] * mag_im[H-1:0];
         hl_im_ff <= mag_im[ACC_W-1:H] * mag_im[H-1:0];
         hh_im_ff <= mag_im[ACC_W-1:H] * mag_im[ACC_W-1:H];
      end
   end

   // recombine each square (mod 2^64)
   always_ff @(posedge clock) begin
      if (ctrl.comb_en) begin
         sq_re_ff <= (64'(hh_re_ff) << (2 * H)) + (64'(hl_re_ff) << (H + 1)) + 64'(ll_re_ff);
         sq_im_ff <= (64'(hh_im_ff) << (2 * H)) + (64'(hl_im_ff) << (H + 1)) + 64'(ll_im_ff);
      end
   end

   // final sum
   assign sq_sum = sq_re_ff + sq_im_ff;

   always_ff @(posedge clock) begin
      if (ctrl.pow_en) begin
         power_ff <= sq_sum[scc_pkg::POWER_BITS-1:0];
      end
   end

   assign power = power_ff;

endmodule

`default_nettype wire

### rtl/sliding_complex_correlation_peak.sv
// Sliding complex correlator with per-block peak report. Taps and window in RAM.
// Tap loads and data items without a full window are taken while the sequencer stays
// idle, except a data item that ends a block, which is followed by a peak report. A full
// window runs one tap per cycle through the MAC, then the 3-stage power unit, then emits
// the correlation result and, at a block end, a peak report; new items stall meanwhile.
// Synchronous active-high reset clears control, the sample count and peak state; RAM
// contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sliding_complex_correlation_peak #(
   parameter int MAX_TAPS      = 128,
   parameter int SAMPLE_BITS   = 12,
   parameter int POSITION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [scc_pkg::PLEN_BITS-1:0]          csr_wr_data,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [scc_pkg::TAP_INDEX_BITS-1:0]     req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_im,
   input  logic                                   req_block_end,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_kind,
   output logic [POSITION_BITS-1:0]               rsp_position,
   output logic signed [scc_pkg::CORR_BITS-1:0]   rsp_corr_re,
   output logic signed [scc_pkg::CORR_BITS-1:0]   rsp_corr_im,
   output logic [scc_pkg::POWER_BITS-1:0]         rsp_power,
   output logic                                   rsp_found,
   output logic                                   rsp_last
);

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int LW    = $clog2(MAX_TAPS + 1);
   localparam int SW    = POSITION_BITS + 1;
   localparam int DW    = 2 * SAMPLE_BITS;
   localparam int ACC_W = 2 * SAMPLE_BITS + 1 + AW;
   localparam int PWB   = scc_pkg::POWER_BITS;
   localparam int CB    = scc_pkg::CORR_BITS;

   scc_pkg::scc_state_type state_ff, state_in;
   scc_pkg::mac_ctrl_type  mac_ctrl;
   scc_pkg::pwr_ctrl_type  pwr_ctrl;

   logic [scc_pkg::PLEN_BITS-1:0] plen_ff, plen_in;
   logic [AW-1:0]        ptr_ff, ptr_in, ptr_next;
   logic [SW-1:0]        seen_ff, seen_in, seen_next;
   logic [LW-1:0]        len_ff, len_in, len_cur;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        waddr_ff, waddr_in, start_addr;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                 end_ff, end_in;
   logic [PWB-1:0]       peak_pow_ff, peak_pow_in;
   logic [POSITION_BITS-1:0] peak_pos_ff, peak_pos_in;
   logic                 peak_valid_ff, peak_valid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [POSITION_BITS-1:0] rsp_position_ff;
   logic signed [CB-1:0] rsp_corr_re_ff, rsp_corr_im_ff;
   logic [PWB-1:0]       rsp_power_ff;
   logic                 rsp_found_ff, rsp_last_ff;

   logic                 in_acc, is_push, full, out_free, load_corr, load_peak, better;
   logic [31:0]          plen_w, len_w, seen_w, pos_w;
   logic [AW+1:0]        start_sum;
   logic                 tap_wr_en, win_wr_en;
   logic [DW-1:0]        tap_word, win_word;
   logic signed [ACC_W-1:0] acc_re, acc_im;
   logic signed [63:0]   acc_re_w, acc_im_w;
   logic                 mac_busy;
   logic [PWB-1:0]       power;

   assign in_acc   = req_valid && !req_stall;
   assign is_push  = (req_cmd == scc_pkg::CMD_PUSH);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != scc_pkg::ST_IDLE);

   // effective pattern length, clamped to 1..MAX_TAPS
   always_comb begin
      plen_w = 32'(plen_ff);
      if (plen_w == 32'd0) begin
         len_w = 32'd1;
      end else if (plen_w > 32'(MAX_TAPS)) begin
         len_w = 32'(MAX_TAPS);
      end else begin
         len_w = plen_w;
      end
      len_cur = len_w[LW-1:0];
   end

   // window pointer, sample count and first read address for this item
   always_comb begin
      ptr_next  = (ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
      seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
      seen_w    = 32'(seen_next);
      full      = (seen_w >= 32'(len_cur));
      pos_w     = seen_w - 32'(len_cur);
      start_sum = (AW+2)'(ptr_next) + (AW+2)'(MAX_TAPS) + (AW+2)'(1) - (AW+2)'(len_cur);
      if (start_sum >= (AW+2)'(MAX_TAPS)) begin
         start_addr = AW'(start_sum - (AW+2)'(MAX_TAPS));
      end else begin
         start_addr = AW'(start_sum);
      end
   end

   // memory write strobes
   assign tap_wr_en = in_acc && (req_cmd == scc_pkg::CMD_LOAD_TAP)
                      && (32'(req_tap_index) < 32'(MAX_TAPS));
   assign win_wr_en = in_acc && is_push;

   scc_ram #(.DEPTH(MAX_TAPS), .WIDTH(DW)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_wr_en),
      .wr_addr (AW'(req_tap_index)),
      .wr_data ({req_sample_re, req_sample_im}),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (tap_word)
   );

   scc_ram #(.DEPTH(MAX_TAPS), .WIDTH(DW)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (ptr_next),
      .wr_data ({req_sample_re, req_sample_im}),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (waddr_ff),
      .rd_data (win_word)
   );

   scc_mac #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .tap_word (tap_word),
      .win_word (win_word),
      .acc_re   (acc_re),
      .acc_im   (acc_im),
      .busy     (mac_busy)
   );

   scc_power #(.ACC_W(ACC_W)) u_power (
      .clock  (clock),
      .ctrl   (pwr_ctrl),
      .acc_re (acc_re),
      .acc_im (acc_im),
      .power  (power)
   );

   // sequencer: next state and control
   always_comb begin
      state_in  = state_ff;
      mac_ctrl  = '0;
      pwr_ctrl  = '0;
      load_corr = 1'b0;
      load_peak = 1'b0;
      case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (in_acc && is_push) begin
               if (full) begin
                  mac_ctrl.clear = 1'b1;
                  state_in = scc_pkg::ST_MAC;
               end else if (req_block_end) begin
                  state_in = scc_pkg::ST_EMIT_PEAK;
               end
            end
         end
         scc_pkg::ST_MAC: begin
            if (cnt_ff != len_ff) begin
               mac_ctrl.issue = 1'b1;
            end else if (!mac_busy) begin
               state_in = scc_pkg::ST_SQUARE;
            end
         end
         scc_pkg::ST_SQUARE: begin
            pwr_ctrl.sq_en = 1'b1;
            state_in = scc_pkg::ST_COMBINE;
         end
         scc_pkg::ST_COMBINE: begin
            pwr_ctrl.comb_en = 1'b1;
            state_in = scc_pkg::ST_POWER;
         end
         scc_pkg::ST_POWER: begin
            pwr_ctrl.pow_en = 1'b1;
            state_in = scc_pkg::ST_EMIT_CORR;
         end
         scc_pkg::ST_EMIT_CORR: begin
            if (out_free) begin
               load_corr = 1'b1;
               state_in  = end_ff ? scc_pkg::ST_EMIT_PEAK : scc_pkg::ST_IDLE;
            end
         end
         scc_pkg::ST_EMIT_PEAK: begin
            if (out_free) begin
               load_peak = 1'b1;
               state_in  = scc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      plen_in       = csr_wr_en ? csr_wr_data : plen_ff;
      ptr_in        = ptr_ff;
      seen_in       = seen_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      waddr_in      = waddr_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      peak_pow_in   = peak_pow_ff;
      peak_pos_in   = peak_pos_ff;
      peak_valid_in = peak_valid_ff;
      better        = !peak_valid_ff || (power > peak_pow_ff);

      if (in_acc && is_push) begin
         ptr_in   = ptr_next;
         seen_in  = seen_next;
         len_in   = len_cur;
         cnt_in   = '0;
         waddr_in = start_addr;
         pos_in   = pos_w[POSITION_BITS-1:0];
         end_in   = req_block_end;
      end

      // walk taps forward and window from oldest to newest
      if (mac_ctrl.issue) begin
         cnt_in   = cnt_ff + 1'b1;
         waddr_in = (waddr_ff == AW'(MAX_TAPS - 1)) ? '0 : waddr_ff + 1'b1;
      end

      // keep the first maximum
      if (load_corr && better) begin
         peak_valid_in = 1'b1;
         peak_pow_in   = power;
         peak_pos_in   = pos_ff;
      end

      // block end clears block state
      if (load_peak) begin
         seen_in       = '0;
         peak_valid_in = 1'b0;
         peak_pow_in   = '0;
         peak_pos_in   = '0;
      end
   end

   // control and block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scc_pkg::ST_IDLE;
         plen_ff       <= scc_pkg::PLEN_RESET;
         ptr_ff        <= '0;
         seen_ff       <= '0;
         peak_pow_ff   <= '0;
         peak_pos_ff   <= '0;
         peak_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         plen_ff       <= plen_in;
         ptr_ff        <= ptr_in;
         seen_ff       <= seen_in;
         peak_pow_ff   <= peak_pow_in;
         peak_pos_ff   <= peak_pos_in;
         peak_valid_ff <= peak_valid_in;
      end
   end

   // per-item payload registers
   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      cnt_ff   <= cnt_in;
      waddr_ff <= waddr_in;
      pos_ff   <= pos_in;
      end_ff   <= end_in;
   end

   // output register
   assign acc_re_w = {{(64-ACC_W){acc_re[ACC_W-1]}}, acc_re};
   assign acc_im_w = {{(64-ACC_W){acc_im[ACC_W-1]}}, acc_im};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_corr || load_peak) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_corr) begin
         rsp_kind_ff     <= scc_pkg::KIND_CORR;
         rsp_position_ff <= pos_ff;
         rsp_corr_re_ff  <= acc_re_w[CB-1:0];
         rsp_corr_im_ff  <= acc_im_w[CB-1:0];
         rsp_power_ff    <= power;
         rsp_found_ff    <= 1'b0;
         rsp_last_ff     <= !end_ff;
      end else if (load_peak) begin
         rsp_kind_ff     <= scc_pkg::KIND_PEAK;
         rsp_position_ff <= peak_pos_ff;
         rsp_corr_re_ff  <= '0;
         rsp_corr_im_ff  <= '0;
         rsp_power_ff    <= peak_pow_ff;
         rsp_found_ff    <= peak_valid_ff;
         rsp_last_ff     <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_corr_re  = rsp_corr_re_ff;
   assign rsp_corr_im  = rsp_corr_im_ff;
   assign rsp_power    = rsp_power_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTH
   // tap counter never runs past the window length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::ST_MAC) |-> (cnt_ff <= len_ff))
      else $error("tap counter past window length");

   // the accumulator is complete before the power unit samples it
   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::ST_MAC && state_in != scc_pkg::ST_MAC)
      |-> (!mac_busy && cnt_ff == len_ff))
      else $error("left MAC with products in flight");

   // a correlation result always leaves a valid peak behind
   a_peak_set: assert property (@(posedge clock) disable iff (reset)
      load_corr |=> peak_valid_ff)
      else $error("peak not recorded after correlation item");

   // a peak report clears the block state
   a_block_clear: assert property (@(posedge clock) disable iff (reset)
      load_peak |=> (seen_ff == '0 && !peak_valid_ff && peak_pow_ff == '0))
      else $error("block state not cleared after peak report");

   // window pointer stays inside the RAM
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) < 32'(MAX_TAPS))
      else $error("window pointer out of range");
`endif

endmodule

`default_nettype wire

### tb/sliding_complex_correlation_peak_test.sv
// Self-checking testbench for the sliding complex correlator with per-block peak report.
// Drives taps, samples and pattern lengths, predicts every result item in SystemVerilog.
// Depends on rtl/scc_pkg.sv and rtl/sliding_complex_correlation_peak.sv.
`timescale 1ns / 1ps

module sliding_complex_correlation_peak_test;

   localparam int TAPS     = 128;
   localparam int SAMPLE_W = 12;
   localparam int POS_W    = 16;
   // covers the longest item, a 128-tap window, plus a peak report
   localparam int SETTLE   = 160;
   localparam logic [POS_W:0] SEEN_TOP = '1;

   typedef struct packed {
      logic                                 kind;
      logic [POS_W-1:0]                     position;
      logic signed [scc_pkg::CORR_BITS-1:0] corr_re;
      logic signed [scc_pkg::CORR_BITS-1:0] corr_im;
      logic [scc_pkg::POWER_BITS-1:0]       power;
      logic                                 found;
      logic                                 last;
   } corr_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type                          op;
      logic                                cmd;
      logic [scc_pkg::TAP_INDEX_BITS-1:0]  idx;
      logic signed [SAMPLE_W-1:0]          re;
      logic signed [SAMPLE_W-1:0]          im;
      logic                                blk_end;
      int unsigned                         reps;
      logic [scc_pkg::PLEN_BITS-1:0]       plen;
      logic                                typed;
      corr_result_type                     want;
   } stim_row_type;

   localparam corr_result_type SHORT_REPORT =
      '{scc_pkg::KIND_PEAK, '0, '0, '0, '0, 1'b0, 1'b1};

   // DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [scc_pkg::PLEN_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic [scc_pkg::TAP_INDEX_BITS-1:0] req_tap_index = '0;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic req_block_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [POS_W-1:0] rsp_position;
   logic signed [scc_pkg::CORR_BITS-1:0] rsp_corr_re;
   logic signed [scc_pkg::CORR_BITS-1:0] rsp_corr_im;
   logic [scc_pkg::POWER_BITS-1:0] rsp_power;
   logic rsp_found;
   logic rsp_last;

   // mirror of the block state
   logic signed [SAMPLE_W-1:0] tap_re [TAPS];
   logic signed [SAMPLE_W-1:0] tap_im [TAPS];
   logic signed [SAMPLE_W-1:0] win_re [TAPS];
   logic signed [SAMPLE_W-1:0] win_im [TAPS];
   logic [POS_W:0]                 seen_count = '0;
   logic [scc_pkg::POWER_BITS-1:0] best_power = '0;
   logic [POS_W-1:0]               best_pos = '0;
   logic                           best_valid = 1'b0;
   logic [scc_pkg::PLEN_BITS-1:0]  plen_reg = scc_pkg::PLEN_RESET;

   corr_result_type pending_results[$];
   stim_row_type    directed_rows[$];
   int fail_count = 0;

   // idling control shared with the receiver process
   bit idle_on = 1'b0;
   int pressure_seq = 0;
   int pressure_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   sliding_complex_correlation_peak #(
      .MAX_TAPS(TAPS),
      .SAMPLE_BITS(SAMPLE_W),
      .POSITION_BITS(POS_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_tap_index(req_tap_index),
      .req_sample_re(req_sample_re),
      .req_sample_im(req_sample_im),
      .req_block_end(req_block_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_position(rsp_position),
      .rsp_corr_re(rsp_corr_re),
      .rsp_corr_im(rsp_corr_im),
      .rsp_power(rsp_power),
      .rsp_found(rsp_found),
      .rsp_last(rsp_last)
   );

   always #4 clock = ~clock;

   // Predict the result items of one accepted item and advance the mirror state
   task automatic correlate_item(input logic cmd,
                                 input logic [scc_pkg::TAP_INDEX_BITS-1:0] idx,
                                 input logic signed [SAMPLE_W-1:0] s_re,
                                 input logic signed [SAMPLE_W-1:0] s_im,
                                 input logic blk_end,
                                 output corr_result_type res [2], output int n);
      int len;
      int w;
      longint acc_re;
      longint acc_im;
      longint mag_re;
      longint mag_im;
      logic [scc_pkg::POWER_BITS-1:0] pw;
      logic [POS_W-1:0] pos;
      n = 0;
      if (cmd == scc_pkg::CMD_LOAD_TAP) begin
         tap_re[idx] = s_re;
         tap_im[idx] = s_im;
      end else begin
         for (int i = TAPS - 1; i > 0; i--) begin
            win_re[i] = win_re[i-1];
            win_im[i] = win_im[i-1];
         end
         win_re[0] = s_re;
         win_im[0] = s_im;
         if (seen_count != SEEN_TOP) seen_count++;
         len = (plen_reg == 0) ? 1 : ((plen_reg > TAPS) ? TAPS : int'(plen_reg));
         if (int'(seen_count) >= len) begin
            acc_re = 0;
            acc_im = 0;
            for (int j = 0; j < len; j++) begin
               w = len - 1 - j;
               acc_re += longint'(win_re[w]) * longint'(tap_re[j])
                         - longint'(win_im[w]) * longint'(tap_im[j]);
               acc_im += longint'(win_re[w]) * longint'(tap_im[j])
                         + longint'(win_im[w]) * longint'(tap_re[j]);
            end
            mag_re = (acc_re < 0) ? -acc_re : acc_re;
            mag_im = (acc_im < 0) ? -acc_im : acc_im;
            pw = scc_pkg::POWER_BITS'(mag_re * mag_re + mag_im * mag_im);
            pos = POS_W'(int'(seen_count) - len);
            // first maximum wins on ties
            if (!best_valid || pw > best_power) begin
               best_valid = 1'b1;
               best_power = pw;
               best_pos = pos;
            end
            res[n] = '{scc_pkg::KIND_CORR, pos, scc_pkg::CORR_BITS'(acc_re),
                       scc_pkg::CORR_BITS'(acc_im), pw, 1'b0, !blk_end};
            n++;
         end
         if (blk_end) begin
            res[n] = '{scc_pkg::KIND_PEAK, best_pos, '0, '0, best_power, best_valid, 1'b1};
            n++;
            seen_count = '0;
            best_power = '0;
            best_pos = '0;
            best_valid = 1'b0;
         end
      end
   endtask

   function automatic stim_row_type item_row(logic cmd, int idx, int re, int im,
                                             logic blk_end, int unsigned reps);
      stim_row_type r;
      r = '{ROW_ITEM, cmd, scc_pkg::TAP_INDEX_BITS'(idx), SAMPLE_W'(re), SAMPLE_W'(im),
            blk_end, reps, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type csr_row(int v);
      stim_row_type r;
      r = '{ROW_CSR, scc_pkg::CMD_LOAD_TAP, '0, '0, '0, 1'b0, 1,
            scc_pkg::PLEN_BITS'(v), 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type checked(stim_row_type r, corr_result_type want);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_W'(-2048);
         1: return SAMPLE_W'(2047);
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // Offer one item, wait for it to be taken, then queue what it should produce
   task automatic send_item(input logic cmd, input logic [scc_pkg::TAP_INDEX_BITS-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] s_re,
                            input logic signed [SAMPLE_W-1:0] s_im,
                            input logic blk_end, input logic typed,
                            input corr_result_type want);
      corr_result_type res [2];
      int n;
      bit taken;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_tap_index <= idx;
      req_sample_re <= s_re;
      req_sample_im <= s_im;
      req_block_end <= blk_end;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      correlate_item(cmd, idx, s_re, s_im, blk_end, res, n);
      if (typed) pending_results.push_back(want);
      else for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
   endtask

   // Wait until every expected item is out and the block has had time to go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_plen(input logic [scc_pkg::PLEN_BITS-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      plen_reg = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Result checker: sampled mid-cycle, the item moves at the next rising edge
   always @(negedge clock) begin
      corr_result_type exp_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            exp_item = pending_results.pop_front();
            check_field("kind", exp_item.kind, rsp_kind);
            check_field("position", exp_item.position, rsp_position);
            check_field("corr_re", longint'(exp_item.corr_re), longint'(rsp_corr_re));
            check_field("corr_im", longint'(exp_item.corr_im), longint'(rsp_corr_im));
            check_field("power", longint'(exp_item.power), longint'(rsp_power));
            check_field("found", exp_item.found, rsp_found);
            check_field("last", exp_item.last, rsp_last);
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (pressure_seen != pressure_seq) begin
         pressure_seen = pressure_seq;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Run limit, far above the slowest correct run
   initial begin
      #80_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int plen_list [12];
      int eff_len;
      int n_items;
      int blk_count;
      int blk_len;
      logic blk_end;
      plen_list = '{3, 1, 2, 0, 64, 5, 128, 8, 255, 2, 16, 0};
      plen_list[11] = $urandom_range(3, 40);
      foreach (win_re[i]) begin
         win_re[i] = '0;
         win_im[i] = '0;
         tap_re[i] = '0;
         tap_im[i] = '0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every tap so no correlation ever reads an unloaded one
      for (int i = 0; i < TAPS; i++)
         send_item(scc_pkg::CMD_LOAD_TAP, scc_pkg::TAP_INDEX_BITS'(i), rand_sample(),
                   rand_sample(), 1'b0, 1'b0, '0);

      // directed table
      // short block straight after reset: nothing full at the default length
      directed_rows.push_back(checked(item_row(scc_pkg::CMD_PUSH, 0, 5, -7, 1'b1, 1),
                                      SHORT_REPORT));
      directed_rows.push_back(csr_row(1));
      directed_rows.push_back(item_row(scc_pkg::CMD_LOAD_TAP, 0, -2048, 0, 1'b0, 1));
      directed_rows.push_back(checked(item_row(scc_pkg::CMD_PUSH, 0, -2048, 0, 1'b0, 1),
         '{scc_pkg::KIND_CORR, '0, 32'sd4194304, '0, 62'd17592186044416, 1'b0, 1'b1}));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 2047, -2048, 1'b0, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 0, 0, 1'b1, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_LOAD_TAP, 127, 2047, -2048, 1'b0, 1));
      // tap load ignores block_end
      directed_rows.push_back(item_row(scc_pkg::CMD_LOAD_TAP, 0, 2047, 2047, 1'b1, 1));
      // zero length acts as one; equal powers keep the earliest peak
      directed_rows.push_back(csr_row(0));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, -2048, -2048, 1'b0, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, -2048, -2048, 1'b1, 1));
      directed_rows.push_back(csr_row(2));
      directed_rows.push_back(item_row(scc_pkg::CMD_LOAD_TAP, 1, -2048, -2048, 1'b0, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 2047, 2047, 1'b0, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, -2048, 2047, 1'b0, 1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 2047, -2048, 1'b1, 1));
      directed_rows.push_back(csr_row(128));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 100, -100, 1'b0, 3));
      directed_rows.push_back(checked(item_row(scc_pkg::CMD_PUSH, 0, -1, 1, 1'b1, 1),
                                      SHORT_REPORT));
      // above the tap count acts as the full tap count
      directed_rows.push_back(csr_row(255));
      directed_rows.push_back(checked(item_row(scc_pkg::CMD_PUSH, 127, 2047, -2048, 1'b1, 1),
                                      SHORT_REPORT));
      // back-to-back run of one-tap windows, then the block ends
      directed_rows.push_back(csr_row(1));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 1, -1, 1'b0, 20));
      directed_rows.push_back(item_row(scc_pkg::CMD_PUSH, 0, 1, -1, 1'b1, 1));

      foreach (directed_rows[k]) begin
         if (directed_rows[k].op == ROW_CSR) begin
            write_plen(directed_rows[k].plen);
         end else begin
            idle_on = (directed_rows[k].reps == 1);
            repeat (directed_rows[k].reps)
               send_item(directed_rows[k].cmd, directed_rows[k].idx, directed_rows[k].re,
                         directed_rows[k].im, directed_rows[k].blk_end,
                         directed_rows[k].typed, directed_rows[k].want);
         end
      end

      // random phases, one pattern length each
      foreach (plen_list[p]) begin
         write_plen(scc_pkg::PLEN_BITS'(plen_list[p]));
         idle_on = !(p == 4 || p == 11);
         if (p == 2) pressure_seq++;
         eff_len = (plen_list[p] == 0) ? 1 : ((plen_list[p] > TAPS) ? TAPS : plen_list[p]);
         n_items = (eff_len >= 64) ? 70 : 145;
         blk_count = 0;
         blk_len = $urandom_range(eff_len, 2 * eff_len + 4);
         for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(scc_pkg::CMD_LOAD_TAP,
                         scc_pkg::TAP_INDEX_BITS'($urandom_range(0, TAPS - 1)),
                         rand_sample(), rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               blk_count++;
               blk_end = (blk_count >= blk_len);
               send_item(scc_pkg::CMD_PUSH,
                         scc_pkg::TAP_INDEX_BITS'($urandom_range(0, TAPS - 1)),
                         rand_sample(), rand_sample(), blk_end, 1'b0, '0);
               if (blk_end) begin
                  blk_count = 0;
                  // mostly well-formed blocks, now and then a short one
                  if ($urandom_range(0, 7) == 0) blk_len = $urandom_range(1, eff_len);
                  else blk_len = $urandom_range(eff_len, 2 * eff_len + 4);
               end
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
